>>> rtl/core/owr_pkg.sv
`timescale 1ns / 1ps
// Package for the 1-Wire thermometer reader: codes, widths, command/status structs,
// CRC8 and fraction table. No dependencies.
package owr_pkg;

   localparam int SCRATCH_BYTES = 9;
   localparam int ROM_BYTES     = 8;
   localparam int ADDR_W        = 64;
   localparam int TEMP_W        = 19;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int CNT_W         = 4;

   localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
   localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
   localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [3:0] FRAC_MASK     = 4'hF;
   localparam logic signed [7:0] CENTI  = 8'sd100;

   localparam logic [2:0]  MAX_ATTEMPTS_RESET = 3'd3;
   localparam logic [15:0] NOT_FOUND_RESET    = 16'hD8F1;

   localparam logic [6:0] FRAC_TAB [16] = '{
      7'd0, 7'd6, 7'd12, 7'd19, 7'd25, 7'd31, 7'd38, 7'd44,
      7'd50, 7'd56, 7'd63, 7'd69, 7'd75, 7'd81, 7'd88, 7'd94
   };

   typedef enum logic [1:0] {
      OP_START       = 2'd0,
      OP_RESET_REPLY = 2'd1,
      OP_READ_BYTE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_RESET  = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_READ   = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ATTEMPTS = 1'd0,
      CSR_NOT_FOUND    = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_READ_RESET,
      PH_READING,
      PH_WAIT_CONV_RESET,
      PH_WAIT_FINAL
   } phase_type;

   typedef enum logic [3:0] {
      ST_ACCEPT,
      ST_DECIDE,
      ST_SEL_CMD,
      ST_SEL_ROM,
      ST_READ_CMD,
      ST_READS,
      ST_CONV_CMD,
      ST_RESET,
      ST_REPORT
   } state_type;

   typedef enum logic [2:0] {
      WD_RESET,
      WD_SEL_CMD,
      WD_ROM_BYTE,
      WD_READ_CMD,
      WD_CONV_CMD,
      WD_READ,
      WD_REPORT
   } word_type;

   typedef struct packed {
      logic     latch_start;
      logic     attempt_clear;
      logic     attempt_inc;
      logic     begin_attempt;
      logic     take_byte;
      logic     save_reading;
      logic     load;
      word_type word;
      logic     last;
      logic     step_clear;
      logic     step_inc;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic byte_last;
      logic step_last_rom;
      logic step_last_read;
      logic retry;
      logic held_given;
   } dp_status_type;

   // reflected CRC8, poly x^8+x^5+x^4+1
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/owr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on owr_pkg for widths.
interface owr_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [owr_pkg::ADDR_W-1:0]  rom_address;
   logic                        address_given;
   logic                        presence_seen;
   logic [7:0]                  read_data;

   modport source (output valid, opcode, rom_address, address_given, presence_seen,
                   read_data, input ready);
   modport sink   (input valid, opcode, rom_address, address_given, presence_seen,
                   read_data, output ready);
endinterface

interface owr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         kind;
   logic [7:0]                         write_data;
   logic signed [owr_pkg::TEMP_W-1:0]  temperature;
   logic                               reading_ok;
   logic                               last_of_run;

   modport source (output valid, kind, write_data, temperature, reading_ok, last_of_run,
                   input ready);
   modport sink   (input valid, kind, write_data, temperature, reading_ok, last_of_run,
                   output ready);
endinterface

>>> rtl/core/owr_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, held address, CRC, raw bytes, counters, conversion
// and the response output register. Depends on owr_pkg.
module owr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  owr_pkg::ctrl_cmd_type         cmd,
   output owr_pkg::dp_status_type        status,
   input  logic                          csr_write_en,
   input  logic [owr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [owr_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic [owr_pkg::ADDR_W-1:0]    rom_address,
   input  logic                          address_given,
   input  logic [7:0]                    read_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_write_data,
   output logic signed [owr_pkg::TEMP_W-1:0] rsp_temperature,
   output logic                          rsp_reading_ok,
   output logic                          rsp_last_of_run
);
   import owr_pkg::*;

   logic [2:0]          max_att_ff, max_att_in;
   logic [15:0]         nf_ff, nf_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                given_ff, given_in;
   logic [2:0]          att_ff, att_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [7:0]          crc_ff, crc_in;
   logic [7:0]          lo_ff, lo_in;
   logic [7:0]          hi_ff, hi_in;
   logic signed [TEMP_W-1:0] saved_ff, saved_in;
   logic                ok_ff, ok_in;

   logic                valid_ff, valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          wdata_ff, wdata_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                rok_ff, rok_in;
   logic                last_ff, last_in;

   logic signed [11:0]  whole;
   logic signed [19:0]  prod;
   logic signed [TEMP_W-1:0] conv;
   logic                slot_free;

   assign slot_free = !valid_ff || rsp_ready;
   assign whole     = signed'({hi_ff, lo_ff[7:4]});
   assign prod      = whole * CENTI;
   assign conv      = prod[TEMP_W-1:0] + TEMP_W'(FRAC_TAB[lo_ff[3:0] & FRAC_MASK]);

   always_comb begin
      max_att_in = max_att_ff;
      nf_in      = nf_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_ATTEMPTS: max_att_in = csr_write_data[2:0];
            CSR_NOT_FOUND:    nf_in      = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      addr_in  = addr_ff;
      given_in = given_ff;
      att_in   = att_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      step_in  = step_ff;
      saved_in = saved_ff;
      ok_in    = ok_ff;
      if (cmd.latch_start) begin
         addr_in  = rom_address;
         given_in = address_given;
      end
      if (cmd.attempt_clear) att_in = '0;
      if (cmd.attempt_inc)   att_in = att_ff + 3'd1;
      if (cmd.begin_attempt) begin
         cnt_in = '0;
         crc_in = '0;
      end
      if (cmd.take_byte) begin
         crc_in = crc_byte(crc_ff, read_data);
         if (cnt_ff == CNT_W'(0)) lo_in = read_data;
         if (cnt_ff == CNT_W'(1)) hi_in = read_data;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.save_reading) begin
         ok_in    = (crc_ff == 8'd0);
         saved_in = (crc_ff == 8'd0) ? conv : signed'({{3{nf_ff[15]}}, nf_ff});
      end
      if (cmd.step_clear) step_in = '0;
      if (cmd.step_inc)   step_in = step_ff + CNT_W'(1);
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      wdata_in = wdata_ff;
      temp_in  = temp_ff;
      rok_in   = rok_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
         last_in  = cmd.last;
         kind_in  = KIND_WRITE;
         wdata_in = '0;
         temp_in  = '0;
         rok_in   = 1'b0;
         case (cmd.word)
            WD_RESET:    kind_in  = KIND_RESET;
            WD_SEL_CMD:  wdata_in = given_ff ? CMD_MATCH_ROM : CMD_SKIP_ROM;
            WD_ROM_BYTE: wdata_in = addr_ff[{step_ff[2:0], 3'b000} +: 8];
            WD_READ_CMD: wdata_in = CMD_READ_PAD;
            WD_CONV_CMD: wdata_in = CMD_CONVERT;
            WD_READ:     kind_in  = KIND_READ;
            WD_REPORT: begin
               kind_in = KIND_REPORT;
               temp_in = saved_ff;
               rok_in  = ok_ff;
            end
            default:     kind_in  = KIND_RESET;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff <= MAX_ATTEMPTS_RESET;
         nf_ff      <= NOT_FOUND_RESET;
         addr_ff    <= '0;
         given_ff   <= 1'b0;
         att_ff     <= '0;
         cnt_ff     <= '0;
         crc_ff     <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         step_ff    <= '0;
         saved_ff   <= '0;
         ok_ff      <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         max_att_ff <= max_att_in;
         nf_ff      <= nf_in;
         addr_ff    <= addr_in;
         given_ff   <= given_in;
         att_ff     <= att_in;
         cnt_ff     <= cnt_in;
         crc_ff     <= crc_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         step_ff    <= step_in;
         saved_ff   <= saved_in;
         ok_ff      <= ok_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      wdata_ff <= wdata_in;
      temp_ff  <= temp_in;
      rok_ff   <= rok_in;
      last_ff  <= last_in;
   end

   assign status.slot_free      = slot_free;
   assign status.byte_last      = (cnt_ff == CNT_W'(SCRATCH_BYTES - 1));
   assign status.step_last_rom  = (step_ff == CNT_W'(ROM_BYTES - 1));
   assign status.step_last_read = (step_ff == CNT_W'(SCRATCH_BYTES - 1));
   assign status.retry          = (crc_ff != 8'd0) && (att_ff < max_att_ff);
   assign status.held_given     = given_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_write_data  = wdata_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_reading_ok  = rok_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/core/owr_ctrl.sv
`timescale 1ns / 1ps
// Controller: bus phase tracking and word sequencing state machine.
// Depends on owr_pkg; drives owr_dp through the command struct.
module owr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   input  logic                   req_presence,
   output logic                   req_ready,
   input  owr_pkg::dp_status_type status,
   output owr_pkg::ctrl_cmd_type  cmd
);
   import owr_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      conv_ff, conv_in;
   logic      fire;

   assign req_ready = (state_ff == ST_ACCEPT);
   assign fire      = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      conv_in  = conv_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (fire) begin
               if (req_opcode == OP_START && phase_ff == PH_IDLE) begin
                  phase_in = PH_WAIT_READ_RESET;
                  state_in = ST_RESET;
               end else if (req_opcode == OP_RESET_REPLY && phase_ff == PH_WAIT_READ_RESET) begin
                  phase_in = PH_READING;
                  conv_in  = 1'b0;
                  state_in = req_presence ? ST_SEL_CMD : ST_READ_CMD;
               end else if (req_opcode == OP_READ_BYTE && phase_ff == PH_READING) begin
                  if (status.byte_last) state_in = ST_DECIDE;
               end else if (req_opcode == OP_RESET_REPLY && phase_ff == PH_WAIT_CONV_RESET) begin
                  if (req_presence) begin
                     conv_in  = 1'b1;
                     phase_in = PH_WAIT_FINAL;
                     state_in = ST_SEL_CMD;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end else if (req_opcode == OP_RESET_REPLY && phase_ff == PH_WAIT_FINAL) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         ST_DECIDE: begin
            if (status.retry) begin
               phase_in = PH_WAIT_READ_RESET;
               state_in = ST_RESET;
            end else begin
               phase_in = PH_WAIT_CONV_RESET;
               state_in = ST_REPORT;
            end
         end
         ST_SEL_CMD: begin
            if (status.slot_free) begin
               if (status.held_given) state_in = ST_SEL_ROM;
               else                   state_in = conv_ff ? ST_CONV_CMD : ST_READ_CMD;
            end
         end
         ST_SEL_ROM: begin
            if (status.slot_free && status.step_last_rom)
               state_in = conv_ff ? ST_CONV_CMD : ST_READ_CMD;
         end
         ST_READ_CMD: begin
            if (status.slot_free) state_in = ST_READS;
         end
         ST_READS: begin
            if (status.slot_free && status.step_last_read) state_in = ST_ACCEPT;
         end
         ST_CONV_CMD: begin
            if (status.slot_free) state_in = ST_RESET;
         end
         ST_RESET: begin
            if (status.slot_free) state_in = ST_ACCEPT;
         end
         ST_REPORT: begin
            if (status.slot_free) state_in = ST_RESET;
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   // outputs
   always_comb begin
      cmd      = '0;
      cmd.word = WD_RESET;
      case (state_ff)
         ST_ACCEPT: begin
            if (fire && req_opcode == OP_START && phase_ff == PH_IDLE) begin
               cmd.latch_start   = 1'b1;
               cmd.attempt_clear = 1'b1;
               cmd.begin_attempt = 1'b1;
            end
            if (fire && req_opcode == OP_READ_BYTE && phase_ff == PH_READING) begin
               cmd.take_byte   = 1'b1;
               cmd.attempt_inc = status.byte_last;
            end
         end
         ST_DECIDE: begin
            cmd.begin_attempt = status.retry;
            cmd.save_reading  = !status.retry;
         end
         ST_SEL_CMD: begin
            cmd.load       = status.slot_free;
            cmd.word       = WD_SEL_CMD;
            cmd.step_clear = 1'b1;
         end
         ST_SEL_ROM: begin
            cmd.load     = status.slot_free;
            cmd.word     = WD_ROM_BYTE;
            cmd.step_inc = status.slot_free;
         end
         ST_READ_CMD: begin
            cmd.load       = status.slot_free;
            cmd.word       = WD_READ_CMD;
            cmd.step_clear = 1'b1;
         end
         ST_READS: begin
            cmd.load     = status.slot_free;
            cmd.word     = WD_READ;
            cmd.last     = status.step_last_read;
            cmd.step_inc = status.slot_free;
         end
         ST_CONV_CMD: begin
            cmd.load = status.slot_free;
            cmd.word = WD_CONV_CMD;
         end
         ST_RESET: begin
            cmd.load = status.slot_free;
            cmd.word = WD_RESET;
            cmd.last = 1'b1;
         end
         ST_REPORT: begin
            cmd.load = status.slot_free;
            cmd.word = WD_REPORT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         phase_ff <= PH_IDLE;
         conv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         conv_ff  <= conv_in;
      end
   end

endmodule

>>> rtl/core/onewire_thermometer_reader.sv
`timescale 1ns / 1ps
// Top level of the 1-Wire thermometer scratchpad reader: controller plus datapath.
// Depends on owr_pkg, owr_if, owr_ctrl and owr_dp.
//
// The block turns start requests and bus replies into byte-level bus words, one
// word per cycle into a single output register while rsp_bus.ready keeps up.
// A request word is taken when ready; req_bus.ready then stays low while the
// words it causes are queued (at most 19 words, for a read with match ROM: 0x55,
// eight address bytes, 0xBE and nine reads), a wait that any output stall
// stretches. The ninth read byte also passes through a decision state for the
// CRC check, retry choice and the temperature conversion (one 12x8 multiply plus
// a table add). Requests that do not fit the current bus phase are taken and
// dropped. Write the CSRs only while idle.
module onewire_thermometer_reader (
   input  logic                           clock,
   input  logic                           reset,
   owr_req_if.sink                        req_bus,
   owr_rsp_if.source                      rsp_bus,
   input  logic                           csr_write_en,
   input  logic [owr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owr_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import owr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   owr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_opcode   (req_bus.opcode),
      .req_presence (req_bus.presence_seen),
      .req_ready    (req_bus.ready),
      .status       (status),
      .cmd          (cmd)
   );

   owr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rom_address     (req_bus.rom_address),
      .address_given   (req_bus.address_given),
      .read_data       (req_bus.read_data),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_kind        (rsp_bus.kind),
      .rsp_write_data  (rsp_bus.write_data),
      .rsp_temperature (rsp_bus.temperature),
      .rsp_reading_ok  (rsp_bus.reading_ok),
      .rsp_last_of_run (rsp_bus.last_of_run)
   );

   a_report_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == KIND_REPORT |-> !rsp_bus.last_of_run)
      else $error("report word flagged as last of run");

   a_ok_only_on_report: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.reading_ok |-> rsp_bus.kind == KIND_REPORT)
      else $error("reading_ok set on a non-report word");

   a_data_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != KIND_WRITE |-> rsp_bus.write_data == 8'd0)
      else $error("write_data nonzero on a non-write word");

   a_no_load_over_held: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !cmd.load)
      else $error("output register reloaded while stalled");

endmodule

>>> tb/owr_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench types for the 1-Wire thermometer reader: the request and bus word records
// and a bit-serial CRC8 update. Depends on owr_pkg.
package owr_tb_pkg;
   import owr_pkg::*;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] rom_address;
      logic              address_given;
      logic              presence_seen;
      logic [7:0]        read_data;
   } bus_request_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        write_data;
      logic [TEMP_W-1:0] temperature;
      logic              reading_ok;
      logic              last_of_run;
   } bus_word_type;

   // one data bit at a time, LSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         if (acc[0] ^ data[i]) acc = (acc >> 1) ^ 8'h8C;
         else acc = acc >> 1;
      end
      return acc;
   endfunction

endpackage

>>> tb/owr_reading_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 1-Wire thermometer reader: mirrors the sequencer, predicts the bus
// words each accepted request causes and checks response words in order.
// Depends on owr_pkg, owr_if and owr_tb_pkg.
module owr_reading_checker (
   input  logic                           clock,
   input  logic                           reset,
   owr_req_if                             req_bus,
   owr_rsp_if                             rsp_bus,
   input  logic                           csr_write_en,
   input  logic [owr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owr_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                             pending_words,
   output int                             fail_count
);
   import owr_pkg::*;
   import owr_tb_pkg::*;

   localparam int FRAC_HUNDREDTHS [16] = '{
      0, 6, 12, 19, 25, 31, 38, 44, 50, 56, 63, 69, 75, 81, 88, 94
   };

   logic [2:0]        attempts_allowed;
   logic [15:0]       absent_code;
   phase_type         bus_phase;
   logic [2:0]        attempts_done;
   logic [3:0]        pad_count;
   logic [7:0]        pad_crc;
   logic [7:0]        raw_lo;
   logic [7:0]        raw_hi;
   logic [ADDR_W-1:0] rom_code;
   logic              rom_given;
   logic [TEMP_W-1:0] last_reading;
   bus_word_type      expected_words [$];
   bus_word_type      step_words [$];
   int                waiting = 0;
   int                failures = 0;

   assign pending_words = waiting;
   assign fail_count    = failures;

   function automatic void add_word(kind_type kind, logic [7:0] data,
                                    logic [TEMP_W-1:0] reading, logic ok);
      bus_word_type w;
      w = '{kind, data, reading, ok, 1'b0};
      step_words.push_back(w);
   endfunction

   function automatic void add_select();
      if (rom_given) begin
         add_word(KIND_WRITE, CMD_MATCH_ROM, '0, 1'b0);
         for (int i = 0; i < ROM_BYTES; i++) add_word(KIND_WRITE, rom_code[8*i +: 8], '0, 1'b0);
      end else begin
         add_word(KIND_WRITE, CMD_SKIP_ROM, '0, 1'b0);
      end
   endfunction

   function automatic void start_attempt();
      pad_count = '0;
      pad_crc   = '0;
      bus_phase = PH_WAIT_READ_RESET;
   endfunction

   function automatic logic [TEMP_W-1:0] centidegrees(logic [15:0] raw);
      int whole;
      int value;
      whole = int'($signed(raw)) >>> 4;
      value = whole * CENTI + FRAC_HUNDREDTHS[raw[3:0]];
      return value[TEMP_W-1:0];
   endfunction

   function automatic void predict_step(bus_request_type r);
      bus_word_type w;
      step_words.delete();
      if (r.opcode == OP_START && bus_phase == PH_IDLE) begin
         rom_code      = r.rom_address;
         rom_given     = r.address_given;
         attempts_done = '0;
         start_attempt();
         add_word(KIND_RESET, '0, '0, 1'b0);
      end else if (r.opcode == OP_RESET_REPLY && bus_phase == PH_WAIT_READ_RESET) begin
         if (r.presence_seen) add_select();
         add_word(KIND_WRITE, CMD_READ_PAD, '0, 1'b0);
         for (int i = 0; i < SCRATCH_BYTES; i++) add_word(KIND_READ, '0, '0, 1'b0);
         bus_phase = PH_READING;
      end else if (r.opcode == OP_READ_BYTE && bus_phase == PH_READING) begin
         pad_crc = crc8_update(pad_crc, r.read_data);
         if (pad_count == 0) raw_lo = r.read_data;
         else if (pad_count == 1) raw_hi = r.read_data;
         pad_count = pad_count + 1'b1;
         if (pad_count >= SCRATCH_BYTES) begin
            attempts_done = attempts_done + 1'b1;
            if (pad_crc != 0 && attempts_done < attempts_allowed) begin
               start_attempt();
               add_word(KIND_RESET, '0, '0, 1'b0);
            end else begin
               last_reading = (pad_crc == 0) ? centidegrees({raw_hi, raw_lo})
                                             : {{(TEMP_W-16){absent_code[15]}}, absent_code};
               add_word(KIND_REPORT, '0, last_reading, pad_crc == 0);
               add_word(KIND_RESET, '0, '0, 1'b0);
               bus_phase = PH_WAIT_CONV_RESET;
            end
         end
      end else if (r.opcode == OP_RESET_REPLY && bus_phase == PH_WAIT_CONV_RESET) begin
         if (r.presence_seen) begin
            add_select();
            add_word(KIND_WRITE, CMD_CONVERT, '0, 1'b0);
            add_word(KIND_RESET, '0, '0, 1'b0);
            bus_phase = PH_WAIT_FINAL;
         end else begin
            bus_phase = PH_IDLE;
         end
      end else if (r.opcode == OP_RESET_REPLY && bus_phase == PH_WAIT_FINAL) begin
         bus_phase = PH_IDLE;
      end
      if (step_words.size() != 0) begin
         w = step_words.pop_back();
         w.last_of_run = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   function automatic string word_text(bus_word_type w);
      return $sformatf("kind %0d data %h temp %0d ok %b last %b", w.kind, w.write_data,
                       $signed(w.temperature), w.reading_ok, w.last_of_run);
   endfunction

   always @(posedge clock) begin
      bus_word_type    seen;
      bus_word_type    want;
      bus_request_type taken;
      if (reset) begin
         attempts_allowed = MAX_ATTEMPTS_RESET;
         absent_code      = NOT_FOUND_RESET;
         bus_phase        = PH_IDLE;
         attempts_done    = '0;
         pad_count        = '0;
         pad_crc          = '0;
         raw_lo           = '0;
         raw_hi           = '0;
         rom_code         = '0;
         rom_given        = 1'b0;
         last_reading     = '0;
         expected_words.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_MAX_ATTEMPTS) attempts_allowed = csr_write_data[2:0];
            else if (csr_index == CSR_NOT_FOUND) absent_code = csr_write_data;
         end
         // check first, so a word can never match an expectation made at the same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{kind_type'(rsp_bus.kind), rsp_bus.write_data, rsp_bus.temperature,
                     rsp_bus.reading_ok, rsp_bus.last_of_run};
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= 10) $display("%0t unexpected word: %s", $time, word_text(seen));
            end else begin
               want = expected_words.pop_front();
               if (seen !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t word mismatch: expected %s, got %s", $time,
                              word_text(want), word_text(seen));
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken = '{req_bus.opcode, req_bus.rom_address, req_bus.address_given,
                      req_bus.presence_seen, req_bus.read_data};
            predict_step(taken);
         end
      end
      waiting <= expected_words.size();
   end

endmodule

>>> tb/onewire_thermometer_reader_tb.sv
`timescale 1ns / 1ps
// Top of the 1-Wire thermometer reader testbench: drives request words, CSR writes and
// response back-pressure, and gives the verdict. Depends on owr_pkg, owr_if,
// owr_tb_pkg, owr_reading_checker and the reader RTL.
module onewire_thermometer_reader_tb;
   import owr_pkg::*;
   import owr_tb_pkg::*;

   localparam int READ_ITEMS = 280;
   localparam int PHASES     = 8;
   localparam int NOISE_PCT  = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    pending_words;
   int                    fail_count;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    items_sent = 0;
   logic [2:0]            cur_max_attempts = MAX_ATTEMPTS_RESET;
   logic [2:0]            attempt_plan [PHASES] = '{3'd3, 3'd1, 3'd7, 3'd0,
                                                    3'd2, 3'd5, 3'd4, 3'd6};
   logic [15:0]           code_plan [PHASES] = '{NOT_FOUND_RESET, 16'h8000, 16'h7FFF,
                                                 16'h0000, 16'hFFFF, 16'h0001,
                                                 16'h1234, 16'hFC18};

   owr_req_if req_bus ();
   owr_rsp_if rsp_bus ();

   onewire_thermometer_reader DUT (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   owr_reading_checker reading_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .pending_words  (pending_words),
      .fail_count     (fail_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic bus_request_type random_request(logic [1:0] op);
      bus_request_type r;
      r.opcode        = op;
      r.rom_address   = {$urandom, $urandom};
      r.address_given = ($urandom_range(1) == 1);
      r.presence_seen = ($urandom_range(1) == 1);
      r.read_data     = 8'($urandom);
      return r;
   endfunction

   // a word the sequencer must drop in the given phase
   function automatic bus_request_type noise_for(phase_type from_phase);
      bus_request_type r;
      r = random_request(2'($urandom_range(3)));
      while ((r.opcode == OP_START && from_phase == PH_IDLE) ||
             (r.opcode == OP_RESET_REPLY && from_phase != PH_IDLE &&
              from_phase != PH_READING) ||
             (r.opcode == OP_READ_BYTE && from_phase == PH_READING)) begin
         r.opcode = 2'($urandom_range(3));
      end
      return r;
   endfunction

   task automatic send_word(input bus_request_type w);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= w.opcode;
      req_bus.rom_address   <= w.rom_address;
      req_bus.address_given <= w.address_given;
      req_bus.presence_seen <= w.presence_seen;
      req_bus.read_data     <= w.read_data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_step(input bus_request_type w, input phase_type from_phase);
      if ($urandom_range(99) < NOISE_PCT) send_word(noise_for(from_phase));
      send_word(w);
      items_sent++;
   endtask

   task automatic wait_for_quiet(input int tail);
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_config(input logic [2:0] attempts, input logic [15:0] code);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MAX_ATTEMPTS;
      csr_write_data <= {13'b0, attempts};
      @(posedge clock);
      csr_index      <= CSR_NOT_FOUND;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cur_max_attempts = attempts;
   endtask

   // nine pad bytes; a bad pad has a corrupted CRC byte
   task automatic send_pad(input logic good, input logic [15:0] raw);
      logic [7:0] pad [SCRATCH_BYTES];
      logic [7:0] crc;
      bus_request_type w;
      crc    = '0;
      pad[0] = raw[7:0];
      pad[1] = raw[15:8];
      for (int i = 2; i < SCRATCH_BYTES - 1; i++) pad[i] = 8'($urandom);
      for (int i = 0; i < SCRATCH_BYTES - 1; i++) crc = crc8_update(crc, pad[i]);
      pad[SCRATCH_BYTES-1] = good ? crc : crc ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < SCRATCH_BYTES; i++) begin
         w = random_request(OP_READ_BYTE);
         w.read_data = pad[i];
         send_step(w, PH_READING);
      end
   endtask

   task automatic run_read(input logic [ADDR_W-1:0] addr, input logic given,
                           input int presence_pct, input int good_pct,
                           input logic [15:0] raw, input logic conv_presence);
      int tries;
      int limit;
      logic good;
      bus_request_type w;
      tries = 0;
      limit = (cur_max_attempts == 0) ? 1 : int'(cur_max_attempts);
      w = random_request(OP_START);
      w.rom_address   = addr;
      w.address_given = given;
      send_step(w, PH_IDLE);
      do begin
         tries++;
         w = random_request(OP_RESET_REPLY);
         w.presence_seen = ($urandom_range(99) < presence_pct);
         send_step(w, PH_WAIT_READ_RESET);
         good = ($urandom_range(99) < good_pct);
         send_pad(good, raw);
      end while (!good && tries < limit);
      w = random_request(OP_RESET_REPLY);
      w.presence_seen = conv_presence;
      send_step(w, PH_WAIT_CONV_RESET);
      if (conv_presence) send_step(random_request(OP_RESET_REPLY), PH_WAIT_FINAL);
   endtask

   task automatic run_random_read();
      logic [ADDR_W-1:0] addr;
      logic [15:0] raw;
      case ($urandom_range(7))
         0: addr = '0;
         1: addr = '1;
         default: addr = {$urandom, $urandom};
      endcase
      case ($urandom_range(11))
         0: raw = 16'h8000;
         1: raw = 16'h7FFF;
         2: raw = 16'h0000;
         3: raw = 16'hFFFF;
         default: raw = 16'($urandom);
      endcase
      run_read(addr, $urandom_range(1) == 1, 80, 55, raw, $urandom_range(99) < 85);
      if ($urandom_range(3) == 0) wait_for_quiet(0);
   endtask

   initial begin
      int target;
      logic [15:0] code;
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = CSR_MAX_ATTEMPTS;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = '0;
      req_bus.rom_address   = '0;
      req_bus.address_given = 1'b0;
      req_bus.presence_seen = 1'b0;
      req_bus.read_data     = '0;
      rsp_bus.ready         = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset config: match ROM, highest temperature, full conversion
      run_read('1, 1'b1, 100, 100, 16'h7FFF, 1'b1);
      wait_for_quiet(30);
      // one attempt, skip ROM, no presence anywhere, most negative fail code
      write_config(3'd1, 16'h8000);
      run_read('0, 1'b0, 0, 0, 16'h0000, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         wait_for_quiet(30);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         code = (p == PHASES - 1) ? 16'($urandom) : code_plan[p];
         write_config(attempt_plan[p], code);
         // cumulative budget keeps the total near READ_ITEMS
         target = READ_ITEMS * (p + 1) / PHASES;
         while (items_sent < target) run_random_read();
      end
      wait_for_quiet(40);

      if (fail_count == 0 && pending_words == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
